@@ rtl/ihp_pkg.sv @@
// Package for the IPv4 header parser: record kinds, record struct, widths.
// Used by every module of the parser; depends on nothing.
`timescale 1ns / 1ps
package ihp_pkg;

  localparam int unsigned CountWidth = 16;

  typedef enum logic [1:0] {
    KIND_OPTION = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_FRAME  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  localparam logic [7:0] OptEool = 8'h00;
  localparam logic [7:0] OptNop  = 8'h01;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] addresses;
    logic [7:0]  lead_byte;
    logic [7:0]  service_byte;
    logic [15:0] length_value;
    logic [15:0] ident_value;
    logic [2:0]  frag_flags;
    logic [12:0] frag_offset;
    logic [15:0] ttl_proto;
    logic        valid_flag;
    logic [15:0] expected_checksum;
    logic        last;
  } rec_t;

  // Ones-complement 16-bit add with end-around carry.
  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    logic [16:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = {1'b0, s[15:0]} + {16'd0, s[16]};
    return t[15:0];
  endfunction

endpackage

@@ rtl/ihp_front.sv @@
// Front end: accepts bytes, keeps header fields, checksum and option walk,
// and emits up to three records per byte as one bundle. Uses ihp_pkg.
`timescale 1ns / 1ps
module ihp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_end_i,
  output logic                take_o,
  output ihp_pkg::rec_t [2:0] recs_o,
  output logic [1:0]          count_o
);
  import ihp_pkg::*;

  localparam int unsigned CW = CountWidth;

  logic [CW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [15:0]    sum_q, sum_d;
  logic [7:0]     hi_q, hi_d;
  logic [7:0]     hb_q [20];
  phase_e         ph_q, ph_d;
  logic [5:0]     left_q, left_d;
  logic [7:0]     dleft_q, dleft_d;
  logic [7:0]     otype_q, otype_d;
  logic [5:0]     ostart_q, ostart_d;
  logic           rep_q, rep_d;

  // Current view of header bytes including this beat's byte.
  logic [7:0]     hb [20];
  logic [3:0]     ihl;
  logic [6:0]     ihl4, hlen;
  logic [15:0]    sum_now, s_fin, x_fin, w10, tot;
  logic           in_sum, opt_en, do_hdr, odd;
  logic           opt_emit;
  logic [15:0]    opt_len;
  logic           opt_ok;
  rec_t           orec, hrec, frec;
  logic [CW:0]    after, trl, pay;
  logic [1:0]     n;

  assign take_o = in_valid_i;

  always_comb begin
    for (int i = 0; i < 20; i++) begin
      hb[i] = (cnt_q == CW'(i)) ? data_byte_i : hb_q[i];
    end
  end

  assign ihl  = hb[0][3:0];
  assign ihl4 = {1'b0, ihl, 2'b00};
  assign hlen = (ihl < 4'd5) ? 7'd20 : ihl4;
  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + CW'(1);
  assign in_sum = cnt_q < CW'(ihl4);
  assign w10 = {hb[10], hb[11]};
  assign tot = {hb[2], hb[3]};

  // Checksum accumulate and option walk.
  always_comb begin
    logic [5:0] lft;
    hi_d = hi_q; sum_d = sum_q;
    ph_d = ph_q; left_d = left_q; dleft_d = dleft_q;
    otype_d = otype_q; ostart_d = ostart_q;
    opt_emit = 1'b0; opt_len = 16'd0; opt_ok = 1'b0;
    lft = (cnt_q == '0) ? 6'(hlen - 7'd20) : left_q;
    left_d = lft;
    sum_now = sum_q;
    if (in_sum) begin
      if (!cnt_q[0]) hi_d = data_byte_i;
      else sum_now = oc_add(sum_q, {hi_q, data_byte_i});
    end
    sum_d = sum_now;
    opt_en = cnt_q >= CW'(20) && cnt_q < CW'(hlen) && lft != 6'd0 && ph_q != PH_DONE;
    if (opt_en) begin
      unique case (ph_q)
        PH_TYPE: begin
          ostart_d = cnt_q[5:0];
          otype_d = data_byte_i;
          if (data_byte_i == OptEool || data_byte_i == OptNop) begin
            opt_emit = 1'b1; opt_len = 16'd1; opt_ok = 1'b1;
            left_d = lft - 6'd1;
          end else if (lft == 6'd1) begin
            opt_emit = 1'b1; left_d = 6'd0; ph_d = PH_DONE;
          end else begin
            left_d = lft - 6'd1; ph_d = PH_LEN;
          end
        end
        PH_LEN: begin
          opt_emit = 1'b1; opt_len = {8'd0, data_byte_i};
          if (data_byte_i < 8'd2 || {1'b0, data_byte_i} > {3'd0, lft} + 9'd1) begin
            ph_d = PH_DONE;
          end else begin
            opt_ok = 1'b1; left_d = lft - 6'd1;
            dleft_d = data_byte_i - 8'd2;
            ph_d = (dleft_d != 8'd0) ? PH_DATA : PH_TYPE;
          end
        end
        PH_DATA: begin
          left_d = lft - 6'd1;
          if (dleft_q != 8'd0) dleft_d = dleft_q - 8'd1;
          if (dleft_d == 8'd0) ph_d = PH_TYPE;
        end
        default: ;
      endcase
    end
  end

  // Header and option record assembly.
  always_comb begin
    do_hdr = !rep_q && ((cnt_inc == CW'(hlen)) || (frame_end_i && cnt_inc >= CW'(20)));
    odd = (cnt_inc != CW'(hlen)) && cnt_inc[0] && cnt_inc < CW'(ihl4);
    s_fin = odd ? oc_add(sum_now, {hi_d, 8'd0}) : sum_now;
    x_fin = (ihl >= 4'd3) ? oc_add(s_fin, ~w10) : s_fin;
    hrec = '0;
    hrec.kind = KIND_HEADER;
    hrec.addresses = {hb[12], hb[13], hb[14], hb[15], hb[16], hb[17], hb[18], hb[19]};
    hrec.lead_byte = hb[0];
    hrec.service_byte = hb[1];
    hrec.length_value = tot;
    hrec.ident_value = {hb[4], hb[5]};
    hrec.frag_flags = hb[6][7:5];
    hrec.frag_offset = {hb[6][4:0], hb[7]};
    hrec.ttl_proto = {hb[8], hb[9]};
    hrec.valid_flag = &s_fin;
    hrec.expected_checksum = ~x_fin;
    orec = '0;
    orec.kind = KIND_OPTION;
    orec.lead_byte = otype_d;
    orec.service_byte = {2'b00, ostart_d};
    orec.length_value = opt_len;
    orec.valid_flag = opt_ok;
  end

  // Frame-end lengths.
  always_comb begin
    frec = '0;
    frec.kind = KIND_FRAME;
    after = (cnt_inc > CW'(hlen)) ? {1'b0, cnt_inc} - (CW+1)'(hlen) : '0;
    trl = (cnt_inc > CW'(tot)) ? {1'b0, cnt_inc} - (CW+1)'(tot) : '0;
    pay = after;
    if (tot >= 16'(ihl4) && (CW+1)'(tot - 16'(ihl4)) < after)
      pay = (CW+1)'(tot - 16'(ihl4));
    if (cnt_inc >= CW'(20)) begin
      frec.length_value = (pay > (CW+1)'(16'hFFFF)) ? 16'hFFFF : pay[15:0];
      frec.ident_value = (trl > (CW+1)'(16'hFFFF)) ? 16'hFFFF : trl[15:0];
      frec.valid_flag = 1'b1;
    end
  end

  // Pack records in order option, header, frame end; mark last.
  always_comb begin
    rec_t seq [3];
    logic [1:0] k;
    k = 2'd0;
    seq[0] = '0; seq[1] = '0; seq[2] = '0;
    if (opt_emit) begin seq[k] = orec; k = k + 2'd1; end
    if (do_hdr) begin seq[k] = hrec; k = k + 2'd1; end
    if (frame_end_i) begin seq[k] = frec; k = k + 2'd1; end
    n = k;
    if (k != 2'd0) seq[k - 2'd1].last = 1'b1;
    recs_o[0] = seq[0]; recs_o[1] = seq[1]; recs_o[2] = seq[2];
  end
  assign count_o = n;

  // Next state; frame end returns everything to reset.
  always_comb begin
    cnt_d = cnt_inc;
    rep_d = rep_q || do_hdr;
    if (frame_end_i) begin
      cnt_d = '0; rep_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sum_q <= '0; hi_q <= '0; ph_q <= PH_TYPE;
      left_q <= '0; dleft_q <= '0; otype_q <= '0; ostart_q <= '0; rep_q <= 1'b0;
    end else if (in_valid_i) begin
      cnt_q <= cnt_d; rep_q <= rep_d;
      if (frame_end_i) begin
        sum_q <= '0; hi_q <= '0; ph_q <= PH_TYPE; left_q <= '0;
        dleft_q <= '0; otype_q <= '0; ostart_q <= '0;
      end else begin
        sum_q <= sum_d; hi_q <= hi_d; ph_q <= ph_d; left_q <= left_d;
        dleft_q <= dleft_d; otype_q <= otype_d; ostart_q <= ostart_d;
      end
    end
  end

  // Header byte store, no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      for (int i = 0; i < 20; i++) begin
        if (cnt_q == CW'(i)) hb_q[i] <= data_byte_i;
      end
    end
  end

  property p_rep_clear;
    @(posedge clk_i) disable iff (!rst_ni) (in_valid_i && frame_end_i) |=> !rep_q;
  endproperty
  a_rep_clear: assert property (p_rep_clear) else $error("report flag kept after frame end");

  property p_fe_count;
    @(posedge clk_i) disable iff (!rst_ni) (in_valid_i && frame_end_i) |-> count_o != 2'd0;
  endproperty
  a_fe_count: assert property (p_fe_count) else $error("frame end without record");

  property p_cnt_zero;
    @(posedge clk_i) disable iff (!rst_ni) (in_valid_i && frame_end_i) |=> cnt_q == '0;
  endproperty
  a_cnt_zero: assert property (p_cnt_zero) else $error("count not cleared");

endmodule

@@ rtl/ihp_back.sv @@
// Back end: queue of records, delivered one beat at a time.
// Uses ihp_pkg; fed by ihp_front.
`timescale 1ns / 1ps
module ihp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ihp_pkg::rec_t [2:0] recs_i,
  input  logic [1:0]          count_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ihp_pkg::rec_t       rec_o
);
  import ihp_pkg::*;

  localparam int unsigned Depth = 8;

  rec_t       mem_q [Depth];
  logic [2:0] rd_q, wr_q;
  logic [3:0] used_q, used_d;
  logic       pop;

  // Room must exist for the largest bundle.
  assign full_o = used_q > 4'(Depth - 3);
  assign out_valid_o = used_q != 4'd0;
  assign rec_o = mem_q[rd_q];
  assign pop = out_valid_o && !out_stall_i;

  always_comb begin
    used_d = used_q + (push_i ? {2'b00, count_i} : 4'd0) - (pop ? 4'd1 : 4'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; used_q <= '0;
    end else begin
      used_q <= used_d;
      if (pop) rd_q <= rd_q + 3'd1;
      if (push_i) wr_q <= wr_q + 3'(count_i);
    end
  end

  // Write bundle entries.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < count_i) mem_q[wr_q + 3'(i)] <= recs_i[i];
      end
    end
  end

  property p_no_over;
    @(posedge clk_i) disable iff (!rst_ni) used_q <= 4'(Depth);
  endproperty
  a_no_over: assert property (p_no_over) else $error("queue overflow");

  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && out_stall_i) |=> out_valid_o;
  endproperty
  a_hold: assert property (p_hold) else $error("record dropped while stalled");

  property p_push_room;
    @(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o;
  endproperty
  a_push_room: assert property (p_push_room) else $error("push into full queue");

endmodule

@@ rtl/ipv4_header_parser_unit.sv @@
// Top level of the IPv4 header parser: front end and record queue.
// Depends on ihp_pkg, ihp_front, ihp_back.
//
//  channel | signals                    | direction
//  in      | in_valid_i/in_stall_o      | bytes in
//  out     | out_valid_o/out_stall_i    | records out
//
// One byte per cycle is taken while the eight-entry record queue has room
// for three records.
// Records appear one per cycle while out_stall_i is low; each is registered in the queue before it appears.
// Reset is asynchronous, active low, and clears all control state.
// Output stall backs up the queue and then stalls the input.
`timescale 1ns / 1ps
module ipv4_header_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [63:0] addresses_o,
  output logic [7:0]  lead_byte_o,
  output logic [7:0]  service_byte_o,
  output logic [15:0] length_value_o,
  output logic [15:0] ident_value_o,
  output logic [2:0]  frag_flags_o,
  output logic [12:0] frag_offset_o,
  output logic [15:0] ttl_proto_o,
  output logic        valid_flag_o,
  output logic [15:0] expected_checksum_o,
  output logic        last_o
);
  import ihp_pkg::*;

  rec_t [2:0] recs;
  rec_t       rec;
  logic [1:0] cnt;
  logic       full, take;

  assign in_stall_o = full;

  ihp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i && !full),
    .data_byte_i, .frame_end_i,
    .take_o(take), .recs_o(recs), .count_o(cnt)
  );

  ihp_back u_back (
    .clk_i, .rst_ni,
    .push_i(take), .recs_i(recs), .count_i(cnt),
    .full_o(full), .out_valid_o, .out_stall_i, .rec_o(rec)
  );

  assign kind_o = rec.kind;
  assign addresses_o = rec.addresses;
  assign lead_byte_o = rec.lead_byte;
  assign service_byte_o = rec.service_byte;
  assign length_value_o = rec.length_value;
  assign ident_value_o = rec.ident_value;
  assign frag_flags_o = rec.frag_flags;
  assign frag_offset_o = rec.frag_offset;
  assign ttl_proto_o = rec.ttl_proto;
  assign valid_flag_o = rec.valid_flag;
  assign expected_checksum_o = rec.expected_checksum;
  assign last_o = rec.last;

endmodule

@@ tb/testbench.sv @@
// Testbench for ipv4_header_parser_unit: drives frames byte by byte and checks
// every record against a cycle-free model of the parser. Depends on ihp_pkg.
`timescale 1ns / 1ps
module testbench;
  import ihp_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned CountMax  = (1 << CountWidth) - 1;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        frame_end_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [63:0] addresses_o;
  logic [7:0]  lead_byte_o;
  logic [7:0]  service_byte_o;
  logic [15:0] length_value_o;
  logic [15:0] ident_value_o;
  logic [2:0]  frag_flags_o;
  logic [12:0] frag_offset_o;
  logic [15:0] ttl_proto_o;
  logic        valid_flag_o;
  logic [15:0] expected_checksum_o;
  logic        last_o;

  ipv4_header_parser_unit i_dut (.*);

  // Parser shadow state
  int unsigned frame_bytes;
  logic [15:0] csum_acc;
  logic [7:0]  high_byte;
  logic [7:0]  hdr_bytes [20];
  phase_e      opt_phase;
  int unsigned opt_left;
  int unsigned opt_data_left;
  logic [7:0]  opt_type;
  int unsigned opt_pos;
  bit          hdr_done;

  rec_t        pending_recs [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [15:0] hdr_word(int i);
    return {hdr_bytes[i], hdr_bytes[i+1]};
  endfunction

  function automatic int unsigned ihl_words();
    return 32'(hdr_bytes[0][3:0]);
  endfunction

  function automatic int unsigned hdr_span();
    return (ihl_words() < 5 ? 5 : ihl_words()) * 4;
  endfunction

  function automatic void clear_parser();
    frame_bytes = 0;
    csum_acc = '0;
    high_byte = '0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    opt_phase = PH_TYPE;
    opt_left = 0;
    opt_data_left = 0;
    opt_type = '0;
    opt_pos = 0;
    hdr_done = 1'b0;
  endfunction

  function automatic void push_option(int unsigned len, bit ok);
    rec_t r;
    r = '0;
    r.kind = KIND_OPTION;
    r.lead_byte = opt_type;
    r.service_byte = 8'(opt_pos & 63);
    r.length_value = 16'(len);
    r.valid_flag = ok;
    pending_recs.push_back(r);
  endfunction

  function automatic void push_header(bit odd_tail);
    rec_t r;
    logic [15:0] s;
    logic [15:0] x;
    s = csum_acc;
    if (odd_tail) s = ones_add(s, {high_byte, 8'h00});
    x = s;
    if (ihl_words() >= 3) x = ones_add(s, ~hdr_word(10));
    r = '0;
    r.kind = KIND_HEADER;
    r.addresses = {hdr_word(12), hdr_word(14), hdr_word(16), hdr_word(18)};
    r.lead_byte = hdr_bytes[0];
    r.service_byte = hdr_bytes[1];
    r.length_value = hdr_word(2);
    r.ident_value = hdr_word(4);
    r.frag_flags = hdr_bytes[6][7:5];
    r.frag_offset = 13'(hdr_word(6) & 16'h1fff);
    r.ttl_proto = hdr_word(8);
    r.valid_flag = (s == 16'hffff);
    r.expected_checksum = ~x;
    hdr_done = 1'b1;
    pending_recs.push_back(r);
  endfunction

  function automatic void push_frame_end();
    rec_t r;
    int unsigned tot;
    int unsigned ihl4;
    int unsigned span;
    int unsigned pay;
    int unsigned trl;
    r = '0;
    r.kind = KIND_FRAME;
    if (frame_bytes >= 20) begin
      tot = hdr_word(2);
      ihl4 = ihl_words() * 4;
      span = hdr_span();
      pay = frame_bytes > span ? frame_bytes - span : 0;
      trl = frame_bytes > tot ? frame_bytes - tot : 0;
      if (tot >= ihl4 && tot - ihl4 < pay) pay = tot - ihl4;
      r.length_value = pay > 65535 ? 16'hffff : 16'(pay);
      r.ident_value = trl > 65535 ? 16'hffff : 16'(trl);
      r.valid_flag = 1'b1;
    end
    pending_recs.push_back(r);
  endfunction

  // Advance the option walk by one byte of the option area
  function automatic void walk_options(logic [7:0] b, int unsigned idx);
    case (opt_phase)
      PH_TYPE: begin
        opt_pos = idx & 63;
        opt_type = b;
        if (b == OptEool || b == OptNop) begin
          push_option(1, 1'b1);
          opt_left--;
        end else if (opt_left == 1) begin
          // TLV type with no room left for its length byte
          push_option(0, 1'b0);
          opt_left = 0;
          opt_phase = PH_DONE;
        end else begin
          opt_left--;
          opt_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < 2 || b > opt_left + 1) begin
          push_option(32'(b), 1'b0);
          opt_phase = PH_DONE;
        end else begin
          push_option(32'(b), 1'b1);
          opt_left--;
          opt_data_left = 32'(b) - 2;
          opt_phase = opt_data_left != 0 ? PH_DATA : PH_TYPE;
        end
      end
      PH_DATA: begin
        opt_left--;
        if (opt_data_left != 0) opt_data_left--;
        if (opt_data_left == 0) opt_phase = PH_TYPE;
      end
      default: ;
    endcase
  endfunction

  // Compute the records caused by one accepted byte
  function automatic void predict_byte(logic [7:0] b, logic fe);
    int unsigned idx;
    int unsigned before_n;
    rec_t r;
    idx = frame_bytes;
    before_n = pending_recs.size();
    if (idx < 20) hdr_bytes[idx] = b;
    if (idx == 0) opt_left = hdr_span() - 20;
    if (idx < ihl_words() * 4) begin
      if (idx[0] == 1'b0) high_byte = b;
      else csum_acc = ones_add(csum_acc, {high_byte, b});
    end
    if (idx >= 20 && idx < hdr_span() && opt_left > 0 && opt_phase != PH_DONE)
      walk_options(b, idx);
    if (frame_bytes < CountMax) frame_bytes++;
    if (!hdr_done && frame_bytes == hdr_span()) push_header(1'b0);
    if (fe) begin
      if (!hdr_done && frame_bytes >= 20)
        push_header(frame_bytes[0] && frame_bytes < ihl_words() * 4);
      push_frame_end();
      clear_parser();
    end
    if (pending_recs.size() > before_n) begin
      r = pending_recs.pop_back();
      r.last = 1'b1;
      pending_recs.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] record field %s: got %0h, want %0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Check each record beat against the oldest prediction
  always @(posedge clk_i) begin
    rec_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_recs.size() == 0) begin
        report_mismatch("unexpected", {62'd0, kind_o}, 64'd0);
      end else begin
        w = pending_recs.pop_front();
        if (kind_o != w.kind) report_mismatch("kind", 64'(kind_o), 64'(w.kind));
        if (addresses_o != w.addresses) report_mismatch("addresses", addresses_o, w.addresses);
        if (lead_byte_o != w.lead_byte)
          report_mismatch("lead", 64'(lead_byte_o), 64'(w.lead_byte));
        if (service_byte_o != w.service_byte)
          report_mismatch("service", 64'(service_byte_o), 64'(w.service_byte));
        if (length_value_o != w.length_value)
          report_mismatch("length", 64'(length_value_o), 64'(w.length_value));
        if (ident_value_o != w.ident_value)
          report_mismatch("ident", 64'(ident_value_o), 64'(w.ident_value));
        if (frag_flags_o != w.frag_flags)
          report_mismatch("flags", 64'(frag_flags_o), 64'(w.frag_flags));
        if (frag_offset_o != w.frag_offset)
          report_mismatch("offset", 64'(frag_offset_o), 64'(w.frag_offset));
        if (ttl_proto_o != w.ttl_proto)
          report_mismatch("ttl_proto", 64'(ttl_proto_o), 64'(w.ttl_proto));
        if (valid_flag_o != w.valid_flag)
          report_mismatch("valid", 64'(valid_flag_o), 64'(w.valid_flag));
        if (expected_checksum_o != w.expected_checksum)
          report_mismatch("checksum", 64'(expected_checksum_o), 64'(w.expected_checksum));
        if (last_o != w.last) report_mismatch("last", 64'(last_o), 64'(w.last));
      end
    end
  end

  // Stall the record channel at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // Watchdog: count cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("** ipv4_header_parser_unit: FAILED **");
        $finish;
      end
    end
  end

  // Send one byte and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic fe);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    frame_end_i <= fe;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b, fe);
  endtask

  task automatic send_frame(logic [7:0] q [$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic drain_records();
    while (pending_recs.size() != 0) @(posedge clk_i);
  endtask

  // Fill the option area with a well-formed option list
  task automatic fill_options(ref logic [7:0] q [$], input int unsigned span);
    int unsigned pos;
    int unsigned len;
    int unsigned sel;
    pos = 20;
    while (pos < span) begin
      sel = $urandom_range(3);
      if (sel == 0 || span - pos < 2) begin
        q[pos] = sel == 0 ? OptEool : OptNop;
        pos++;
      end else if (sel == 1) begin
        q[pos] = OptNop;
        pos++;
      end else begin
        len = $urandom_range(2, span - pos);
        q[pos] = 8'($urandom_range(2, 255));
        q[pos+1] = 8'(len);
        for (int i = 2; i < len; i++) q[pos+i] = 8'($urandom);
        pos += len;
      end
    end
  endtask

  // Build a frame: header, options, payload and a short trailer
  task automatic build_frame(ref logic [7:0] q [$], input int unsigned ihl,
                             input int unsigned pay, input bit good_sum);
    int unsigned span;
    int unsigned tot;
    logic [15:0] s;
    span = (ihl < 5 ? 5 : ihl) * 4;
    tot = ihl * 4 + pay;
    q.delete();
    for (int i = 0; i < span + pay + $urandom_range(3); i++) q.push_back(8'($urandom));
    q[0] = {4'h4, 4'(ihl)};
    if ($urandom_range(9) == 0) tot = $urandom_range(65535);
    q[2] = 8'(tot >> 8);
    q[3] = 8'(tot);
    fill_options(q, span);
    if (ihl >= 3) begin
      q[10] = 8'h00;
      q[11] = 8'h00;
    end
    s = '0;
    for (int i = 0; i + 1 < ihl * 4; i += 2) s = ones_add(s, {q[i], q[i+1]});
    if (good_sum && ihl >= 3) begin
      q[10] = ~s[15:8];
      q[11] = ~s[7:0];
    end
  endtask

  task automatic test_plain_headers();
    logic [7:0] q [$];
    build_frame(q, 5, 0, 1'b1);
    send_frame(q);
    // Zero total length: no payload limit
    build_frame(q, 5, 4, 1'b1);
    for (int i = 4; i < q.size(); i++) q[i] = 8'h00;
    q[2] = 8'h00;
    q[3] = 8'h00;
    send_frame(q);
  endtask

  task automatic test_option_walk();
    logic [7:0] q [$];
    // EOOL first, the walk continues past it; the last option overruns the area
    build_frame(q, 7, 0, 1'b0);
    q[20] = OptEool;
    q[21] = OptNop;
    q[22] = 8'h83;
    q[23] = 8'd3;
    q[25] = 8'h07;
    q[26] = 8'd5;
    send_frame(q);
    // Declared length below two
    build_frame(q, 6, 0, 1'b0);
    q[20] = 8'h44;
    q[21] = 8'd1;
    send_frame(q);
    // TLV type on the last option byte
    build_frame(q, 6, 0, 1'b1);
    q[20] = OptNop;
    q[21] = OptNop;
    q[22] = OptNop;
    q[23] = 8'hff;
    send_frame(q);
  endtask

  task automatic test_short_frames();
    logic [7:0] q [$];
    // Small IHL, under the checksum field
    build_frame(q, 2, 0, 1'b0);
    send_frame(q);
    // Truncated header with an odd byte left over
    build_frame(q, 15, 0, 1'b0);
    while (q.size() > 21) void'(q.pop_back());
    send_frame(q);
    // Runt frames
    send_byte(8'h45, 1'b1);
    build_frame(q, 5, 0, 1'b1);
    while (q.size() > 10) void'(q.pop_back());
    send_frame(q);
  endtask

  initial begin
    clear_parser();
    mismatch_count = 0;
    idle_cycles = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    frame_end_i = 1'b0;
    out_stall_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 14;
    rx_idle_pct = 45;
    test_plain_headers();
    tx_idle_pct = 45;
    rx_idle_pct = 14;
    test_option_walk();
    // Hold off the sender until every record is out
    in_valid_i <= 1'b0;
    drain_records();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_short_frames();

    in_valid_i <= 1'b0;
    drain_records();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_recs.size() == 0) begin
      $display("** ipv4_header_parser_unit: PASSED **");
    end else begin
      $display("** ipv4_header_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ihp_pkg.sv
rtl/ihp_front.sv
rtl/ihp_back.sv
rtl/ipv4_header_parser_unit.sv
tb/testbench.sv
